[sv/sha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

  // Block geometry and padding constants.
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned HashWords  = 8;
  localparam logic [7:0]  PadByte    = 8'h80;

  // Controls from the sequencer to the message schedule window.
  typedef struct packed {
    logic        load_byte;
    logic [7:0]  byte_val;
    logic        load_len;
    logic [63:0] len_bits;
    logic        step;
    logic        expand;
  } sched_ctl_t;

  // Controls from the sequencer to the round unit.
  typedef struct packed {
    logic       init;
    logic       round;
    logic [5:0] k_index;
    logic       finalize;
    logic       restart;
  } round_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    case (idx)
      3'd0:    init_hash = 32'h6a09e667;
      3'd1:    init_hash = 32'hbb67ae85;
      3'd2:    init_hash = 32'h3c6ef372;
      3'd3:    init_hash = 32'ha54ff53a;
      3'd4:    init_hash = 32'h510e527f;
      3'd5:    init_hash = 32'h9b05688c;
      3'd6:    init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

`default_nettype wire

[sv/sha256_hash.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Direction  Item
// item      item_valid, item_stall, action,          in         byte or finish
//           data_byte
// digest    digest_valid, digest_stall,              out        one hash word
//           digest_word, word_index, last
//
// Every 64th byte adds a compression (load, 64 rounds, hash update) on the one
// shared round unit. A finish item pads one zero byte per cycle (pausing for a
// compression if the block fills), loads the length, runs one or two compressions,
// then offers eight words, one per cycle while digest_stall is low.
// Reset (synchronous, active high) restores the initial hash and clears the
// counters; item_stall is high unless idle, and a stalled word holds until taken.
module sha256_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam logic [5:0] FillLast    = 6'(BlockBytes - 1);
  localparam logic [5:0] LenFill     = 6'(LenPos);
  localparam logic [6:0] StepLast    = 7'(Rounds - 1);
  localparam logic [6:0] ExpandFirst = 7'd16;
  localparam logic [6:0] RoundLast   = 7'(Rounds);
  localparam logic [6:0] FinalCnt    = 7'(Rounds + 1);
  localparam logic [2:0] WordLast    = 3'(HashWords - 1);

  state_t      state;
  state_t      ret_state;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic [6:0]  cnt;
  logic [2:0]  word_idx;

  logic        item_take;
  logic        digest_take;
  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;
  logic [31:0] w_last;

  assign item_stall   = (state != ST_IDLE);
  assign digest_valid = (state == ST_OUT);
  assign item_take    = item_valid && !item_stall;
  assign digest_take  = digest_valid && !digest_stall;
  assign word_index   = word_idx;
  assign last         = (word_idx == WordLast);

  // Control decode: the state and the round counter steer both units.
  always_comb begin
    sched_ctl          = '0;
    round_ctl          = '0;
    sched_ctl.len_bits = {msg_bytes, 3'b000};
    unique case (state)
      ST_IDLE: begin
        if (item_take) begin
          sched_ctl.load_byte = 1'b1;
          sched_ctl.byte_val  = action ? PadByte : data_byte;
        end
      end
      ST_PAD: begin
        // Zero bytes run up to the length field, which goes in as one word pair.
        if (fill == LenFill) begin
          sched_ctl.load_len = 1'b1;
        end else begin
          sched_ctl.load_byte = 1'b1;
        end
      end
      ST_COMP: begin
        // The schedule runs one step ahead of the rounds.
        sched_ctl.step     = (cnt <= StepLast);
        sched_ctl.expand   = (cnt >= ExpandFirst);
        round_ctl.init     = (cnt == 7'd0);
        round_ctl.round    = (cnt != 7'd0) && (cnt <= RoundLast);
        round_ctl.k_index  = 6'(cnt - 7'd1);
        round_ctl.finalize = (cnt == FinalCnt);
      end
      ST_OUT: begin
        round_ctl.restart = digest_take && last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      fill      <= '0;
      msg_bytes <= '0;
      cnt       <= '0;
      word_idx  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_take) begin
            fill <= fill + 6'd1;
            cnt  <= '0;
            if (!action) begin
              msg_bytes <= msg_bytes + 61'd1;
              if (fill == FillLast) begin
                state     <= ST_COMP;
                ret_state <= ST_IDLE;
              end
            end else if (fill == FillLast) begin
              // The pad byte filled the block, so it is compressed first.
              state     <= ST_COMP;
              ret_state <= ST_PAD;
            end else begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          cnt <= '0;
          if (fill == LenFill) begin
            fill      <= '0;
            state     <= ST_COMP;
            ret_state <= ST_OUT;
          end else begin
            fill <= fill + 6'd1;
            if (fill == FillLast) begin
              state     <= ST_COMP;
              ret_state <= ST_PAD;
            end
          end
        end
        ST_COMP: begin
          if (cnt == FinalCnt) begin
            state    <= ret_state;
            word_idx <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        ST_OUT: begin
          if (digest_take) begin
            word_idx <= word_idx + 3'd1;
            if (last) begin
              state     <= ST_IDLE;
              msg_bytes <= '0;
              fill      <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  sha_sched u_sched (
    .clk    (clk),
    .ctl    (sched_ctl),
    .w_last (w_last)
  );

  sha_round u_round (
    .clk         (clk),
    .rst         (rst),
    .ctl         (round_ctl),
    .w           (w_last),
    .word_sel    (word_idx),
    .digest_word (digest_word)
  );

  // An accepted item never produces a digest word in the very next cycle.
  a_no_early_digest: assert property (@(posedge clk) disable iff (rst)
    item_take |=> !digest_valid)
    else $error("digest offered right after an item was taken");

  // After the final digest word the engine is idle with fill and byte count cleared.
  a_restart_clean: assert property (@(posedge clk) disable iff (rst)
    digest_take && last |=> !item_stall && fill == 6'd0 && msg_bytes == 61'd0)
    else $error("engine not restarted after the last digest word");

  // The round counter never runs past the hash update step.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMP |-> cnt <= FinalCnt)
    else $error("round counter overran");

  // Input and output sides are never open together.
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !digest_valid)
    else $error("input ready while digest pending");

  // The digest is offered only with a block boundary reached.
  a_digest_fill: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> fill == 6'd0)
    else $error("digest offered with a partial block");

endmodule

`default_nettype wire

[sv/sha_sched.sv]
`timescale 1ns / 1ps
`default_nettype none

// 512-bit window that first gathers the block bytes and then rolls the
// message schedule, one word per step. Word 0 sits at the top bits.
module sha_sched (
  input  logic              clk,
  input  sha_pkg::sched_ctl_t ctl,
  output logic [31:0]       w_last
);
  import sha_pkg::*;

  logic [511:0] window;
  logic [31:0]  w_new;
  logic [31:0]  w_in;

  always_comb begin
    w_new = window[511:480] + small_sigma0(window[479:448])
          + window[223:192] + small_sigma1(window[63:32]);
    w_in  = ctl.expand ? w_new : window[511:480];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      window <= {window[503:0], ctl.byte_val};
    end else if (ctl.load_len) begin
      window <= {window[447:0], ctl.len_bits};
    end else if (ctl.step) begin
      window <= {window[479:0], w_in};
    end
  end

  assign w_last = window[31:0];

endmodule

`default_nettype wire

[sv/sha_round.sv]
`timescale 1ns / 1ps
`default_nettype none

// One compression round per cycle on the working variables, plus the
// running hash words that absorb the result at the end of each block.
module sha_round (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::round_ctl_t ctl,
  input  logic [31:0]         w,
  input  logic [2:0]          word_sel,
  output logic [31:0]         digest_word
);
  import sha_pkg::*;

  logic [31:0] hash [HashWords];
  logic [31:0] vars [HashWords];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1  = vars[7] + big_sigma1(vars[4]) + ch + round_k(ctl.k_index) + w;
    t2  = big_sigma0(vars[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      for (int i = 0; i < HashWords; i++) begin
        hash[i] <= init_hash(3'(i));
      end
    end else if (ctl.finalize) begin
      for (int i = 0; i < HashWords; i++) begin
        hash[i] <= hash[i] + vars[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      vars <= hash;
    end else if (ctl.round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  assign digest_word = hash[word_sel];

endmodule

`default_nettype wire

[tb/sha256_hash_checker.sv]
`timescale 1ns / 1ps

package sha256_hash_tb_pkg;

  typedef enum logic {
    ACT_ABSORB = 1'b0,
    ACT_FINISH = 1'b1
  } hash_action_e;

endpackage

module sha256_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  input  logic        digest_valid,
  input  logic        digest_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last,
  output int          mismatch_count,
  output int          words_pending
);
  import sha256_hash_tb_pkg::*;

  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] HashIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_entry_t;

  // Running hash of the message in flight.
  logic [7:0]    msg_block [64];
  int unsigned   block_fill;
  logic [60:0]   msg_len;
  logic [31:0]   chain [8];
  digest_entry_t expected_words [$];
  int            errors;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] both;
    both = {x, x} >> n;
    return both[31:0];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain[i] = HashIv[i];
    block_fill = 0;
    msg_len = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    msg_len = msg_len + 1'b1;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Pads the message, runs the last one or two blocks and queues the digest.
  function automatic void finish_message();
    logic [63:0]   bit_len;
    digest_entry_t entry;
    bit_len = {msg_len, 3'b000};
    msg_block[block_fill] = 8'h80;
    block_fill++;
    if (block_fill > 56) begin
      while (block_fill < 64) begin
        msg_block[block_fill] = 8'h00;
        block_fill++;
      end
      compress_block();
      block_fill = 0;
    end
    while (block_fill < 56) begin
      msg_block[block_fill] = 8'h00;
      block_fill++;
    end
    for (int i = 0; i < 8; i++) msg_block[56 + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      entry.word = chain[i];
      entry.idx = i[2:0];
      entry.is_last = (i == 7);
      expected_words.insert(expected_words.size(), entry);
    end
    restart_message();
  endfunction

  always @(posedge clk) begin
    digest_entry_t want;
    if (rst) begin
      restart_message();
      expected_words.delete();
    end else begin
      if (item_valid && !item_stall) begin
        if (action == ACT_FINISH) finish_message();
        else absorb_byte(data_byte);
      end
      if (digest_valid && !digest_stall) begin
        if (expected_words.size() == 0) begin
          $error("digest_word 0x%08h arrived with no digest outstanding", digest_word);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (digest_word !== want.word) begin
            $error("digest_word: expected 0x%08h, got 0x%08h", want.word, digest_word);
            errors++;
          end
          if (word_index !== want.idx) begin
            $error("word_index: expected %0d, got %0d", want.idx, word_index);
            errors++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0b, got %0b", want.is_last, last);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    words_pending <= expected_words.size();
  end

endmodule

[tb/sha256_hash_tb.sv]
`timescale 1ns / 1ps

// Top of the SHA-256 engine bench. This module only makes traffic and gives
// the verdict; the checker beside the block predicts every digest and
// compares what comes out.
module sha256_hash_tb;
  import sha256_hash_tb_pkg::*;

  // The run is short, so the cycle limit is far above the slowest correct run.
  localparam int CycleLimit = 300000;
  localparam int ItemTarget = 180;
  localparam int WordTarget = 48;
  localparam int LongHold   = 400;
  localparam int DrainWait  = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        action = ACT_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  int mismatch_count;
  int words_pending;
  int cycle_count = 0;

  // Sender bookkeeping: items left in the current burst and items accepted.
  int burst_left = 0;
  int items_sent = 0;

  sha256_hash uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .data_byte    (data_byte),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last         (last)
  );

  sha256_hash_checker chk (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .action         (action),
    .data_byte      (data_byte),
    .digest_valid   (digest_valid),
    .digest_stall   (digest_stall),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last           (last),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one item and returns at the edge where it is taken. Between
  // bursts valid drops for a random gap, so idle cycles land on every
  // phase of the block's work: byte intake, padding, rounds and output.
  // Some bursts are long enough to give stretches with no idling at all.
  task automatic send_item(input hash_action_e act, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 90);
      else burst_left = $urandom_range(1, 12);
    end
    item_valid <= 1'b1;
    action <= act;
    data_byte <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // The receiver stalls on a pattern of its own: segments of random length,
  // each with its own stall density. The first time a digest word shows up
  // it holds off for a long stretch, while the sender keeps offering the
  // next message, so the pending digest backs up into the item channel.
  initial begin : receiver
    int span;
    int mode;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        if (!hold_done && digest_valid) begin
          hold_done = 1'b1;
          digest_stall <= 1'b1;
          repeat (LongHold) @(posedge clk);
        end
        case (mode)
          0: digest_stall <= 1'b0;
          1: digest_stall <= 1'($urandom_range(0, 1));
          2: digest_stall <= ($urandom_range(0, 3) == 0);
          default: digest_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    // Message lengths around the padding boundaries: the last length that
    // pads in one block, the first that needs a second block, a full block
    // and lengths near it, and the same padding pair one block further on.
    int unsigned pad_edges [8];
    int unsigned msg_bytes;
    int          words_due;
    bit          first_long;

    pad_edges = '{55, 56, 57, 63, 64, 65, 119, 120};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty message; the data field of a finish must be ignored.
    send_item(ACT_FINISH, 8'hFF);

    // The classic three-byte message, finish with a zero data field.
    send_item(ACT_ABSORB, 8'h61);
    send_item(ACT_ABSORB, 8'h62);
    send_item(ACT_ABSORB, 8'h63);
    send_item(ACT_FINISH, 8'h00);

    // Extreme and alternating byte values.
    send_item(ACT_ABSORB, 8'h00);
    send_item(ACT_ABSORB, 8'hFF);
    send_item(ACT_ABSORB, 8'hA5);
    send_item(ACT_ABSORB, 8'h5A);
    send_item(ACT_FINISH, 8'($urandom_range(0, 255)));

    // A data byte that looks like the pad marker.
    send_item(ACT_ABSORB, 8'h80);
    send_item(ACT_FINISH, 8'h80);
    words_due = 32;

    // Random messages. The first one always sits on a padding boundary,
    // later ones do so now and then; the rest are short so that many
    // digests come out.
    first_long = 1'b1;
    while (items_sent < ItemTarget || words_due < WordTarget) begin
      if (first_long || $urandom_range(0, 5) == 0) msg_bytes = pad_edges[$urandom_range(0, 7)];
      else msg_bytes = $urandom_range(0, 15);
      first_long = 1'b0;
      repeat (msg_bytes) send_item(ACT_ABSORB, 8'($urandom_range(0, 255)));
      send_item(ACT_FINISH, 8'($urandom_range(0, 255)));
      words_due += 8;
    end
    item_valid <= 1'b0;

    // Let the checker see the last item, then wait for every digest word.
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/sha_pkg.sv
sv/sha_sched.sv
sv/sha_round.sv
sv/sha256_hash.sv
tb/sha256_hash_checker.sv
tb/sha256_hash_tb.sv
